/* rtl/stpg_pkg.sv */
package stpg_pkg;

  // field widths
  localparam int STEP_W   = 17;
  localparam int SPD_W    = 13;
  localparam int RATIO_W  = 16;
  localparam int TIME_W   = 15;
  localparam int STAT_W   = 3;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 4;
  localparam int REG_W    = 2;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 40;
  localparam int PROD_W   = STEP_W + SPD_W;

  // parameter defaults
  localparam int unsigned STEP_COUNT_MAX_DEF = 100000;
  localparam int unsigned TICK_HZ_DEF        = 1000000;

  // limits
  localparam logic [SPD_W-1:0]   SPEED_LO   = 13'd100;
  localparam logic [SPD_W-1:0]   SPEED_HI   = 13'd5000;
  localparam logic [RATIO_W-1:0] RATIO_MAX  = 16'd32768;
  localparam logic [TIME_W-1:0]  HALF_CLAMP = 15'd30000;

  // register reset values
  localparam logic [SPD_W-1:0]   START_SPEED_RST = 13'd200;
  localparam logic [SPD_W-1:0]   MAX_SPEED_RST   = 13'd2000;
  localparam logic [RATIO_W-1:0] RATIO_RST       = 16'd13107;

  // register indexes
  localparam logic [REG_W-1:0] REG_START_SPEED = 2'd0;
  localparam logic [REG_W-1:0] REG_MAX_SPEED   = 2'd1;
  localparam logic [REG_W-1:0] REG_RAMP_RATIO  = 2'd2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_PULSE   = 3'd0,
    ST_STARTED = 3'd1,
    ST_BUSY    = 3'd2,
    ST_BAD     = 3'd3,
    ST_STOPPED = 3'd4,
    ST_IDLE    = 3'd5
  } status_t;

endpackage

/* rtl/stpg_div.sv */
module stpg_div #(
  parameter int NUM_W = stpg_pkg::PROD_W,
  parameter int DEN_W = stpg_pkg::STEP_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             take;

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign take    = rem_sh >= {1'b0, den_r};
  assign done    = cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (cnt != '0) begin
      quo <= {quo[NUM_W-2:0], take};
      rem <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

/* rtl/stepper_trapezoid_pulse_gen.sv */
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser = kind; tdata = step_count, turn_cw
// m_axis    out  m_axis_tvalid/tready      tdata = status, high/low time, dir; tlast
// apb       in   psel/penable/pwrite       start speed, max speed, ramp ratio
//
// Flow: one item at a time, s_axis_tready is high only while the sequencer idles.
//   start, stop, reject or idle answer: no divide (a good start passes the multiplier).
//   cruise pulse: one pass of the serial divider.
//   ramp pulse: speed interpolation, then period divide, both on the shared
//   one-bit-per-cycle divider.
// Reset: synchronous, clears move state, registers to their defaults, output empty.
// Stalls: a held result in the output register only delays the sequencer's hand-off;
//   the next item may be taken once the result is loaded.
module stepper_trapezoid_pulse_gen #(
  parameter int unsigned STEP_COUNT_MAX = stpg_pkg::STEP_COUNT_MAX_DEF,
  parameter int unsigned TICK_HZ        = stpg_pkg::TICK_HZ_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [stpg_pkg::S_DATA_W-1:0] s_axis_tdata,  // [16:0] step_count, [17] turn_cw
  input  logic [stpg_pkg::KIND_W-1:0]   s_axis_tuser,  // [1:0] kind
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [stpg_pkg::M_DATA_W-1:0] m_axis_tdata,  // [2:0] status, [17:3] high_time_us,
                                                       // [32:18] low_time_us, [33] dir_level
  output logic                          m_axis_tlast   // last_step
);
  import stpg_pkg::*;

  localparam int TICK_W = $clog2(TICK_HZ + 1);
  localparam int NUM_W  = (PROD_W > TICK_W) ? PROD_W : TICK_W;
  localparam int MUL_W  = STEP_W + RATIO_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SPLIT = 6'b000100,
    S_DIV1  = 6'b001000,
    S_DIV2  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  // config registers
  logic [SPD_W-1:0]   start_speed_hz;
  logic [SPD_W-1:0]   max_speed_hz;
  logic [RATIO_W-1:0] ramp_ratio_q16;
  logic [REG_W-1:0]   reg_idx;
  logic               cfg_wr;

  // move state
  logic               moving;
  logic [STEP_W-1:0]  step_index;
  logic [STEP_W-1:0]  total_steps;
  logic [STEP_W-1:0]  accel_count;
  logic [STEP_W-1:0]  cruise_count;
  logic [STEP_W-1:0]  decel_count;
  logic               move_dir;
  logic [SPD_W-1:0]   lat_start;
  logic [SPD_W-1:0]   lat_max;

  // work registers
  logic               is_start;
  logic               in_decel;
  logic [STEP_W-1:0]  op_a;
  logic [RATIO_W-1:0] op_b;
  logic [STEP_W-1:0]  den_r;
  logic [MUL_W-1:0]   prod;

  // staged result
  status_t            res_status;
  logic [TIME_W-1:0]  res_hi;
  logic [TIME_W-1:0]  res_lo;
  logic               res_dir;
  logic               res_last;

  // output register
  status_t            out_status;
  logic [TIME_W-1:0]  out_hi;
  logic [TIME_W-1:0]  out_lo;
  logic               out_dir;
  logic               out_last;
  logic               out_free;

  // input decode
  logic               accept;
  logic [KIND_W-1:0]  in_kind;
  logic [STEP_W-1:0]  in_steps;
  logic               in_cw;
  logic               bad_start;

  // pulse region
  logic [SPD_W-1:0]   diff;
  logic [STEP_W:0]    cru_end;
  logic               in_acc;
  logic               in_cru;
  logic [STEP_W-1:0]  dec_idx;

  // shared multiplier
  logic [MUL_W-1:0]   mul_out;

  // start split
  logic [STEP_W-1:0]  acc_raw;
  logic               split_big;
  logic [STEP_W-1:0]  acc_n;
  logic [STEP_W-1:0]  dec_n;

  // shared divider
  logic               dv_start;
  logic [NUM_W-1:0]   dv_num;
  logic [STEP_W-1:0]  dv_den;
  logic               dv_done;
  logic [NUM_W-1:0]   dv_quo;

  // speed and period
  logic [SPD_W-1:0]   sp_dec;
  logic [SPD_W-1:0]   sp_calc;
  logic [NUM_W-1:0]   hi_full;
  logic [NUM_W-1:0]   lo_full;
  logic [TIME_W-1:0]  hi_clamp;
  logic [TIME_W-1:0]  lo_clamp;
  logic [STEP_W-1:0]  idx_inc;
  logic               last_pulse;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_speed_hz <= START_SPEED_RST;
      max_speed_hz   <= MAX_SPEED_RST;
      ramp_ratio_q16 <= RATIO_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_SPEED: start_speed_hz <= pwdata[SPD_W-1:0];
        REG_MAX_SPEED:   max_speed_hz   <= pwdata[SPD_W-1:0];
        REG_RAMP_RATIO:  ramp_ratio_q16 <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_SPEED: prdata = 32'(start_speed_hz);
      REG_MAX_SPEED:   prdata = 32'(max_speed_hz);
      REG_RAMP_RATIO:  prdata = 32'(ramp_ratio_q16);
      default:         prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  assign s_axis_tready = state == S_IDLE;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign in_kind       = s_axis_tuser;
  assign in_steps      = s_axis_tdata[STEP_W-1:0];
  assign in_cw         = s_axis_tdata[STEP_W];

  assign bad_start = (in_steps == '0) || (32'(in_steps) > STEP_COUNT_MAX) ||
                     (max_speed_hz < SPEED_LO) || (max_speed_hz > SPEED_HI) ||
                     (start_speed_hz < SPEED_LO) || (start_speed_hz >= max_speed_hz) ||
                     (ramp_ratio_q16 > RATIO_MAX);

  // which part of the trapezoid the next pulse falls in
  assign diff    = (lat_max > lat_start) ? lat_max - lat_start : '0;
  assign cru_end = {1'b0, accel_count} + {1'b0, cruise_count};
  assign in_acc  = step_index < accel_count;
  assign in_cru  = {1'b0, step_index} < cru_end;
  assign dec_idx = step_index - accel_count - cruise_count;

  // steps*ratio at start, index*(max-start) on the ramps
  assign mul_out = MUL_W'(op_a) * MUL_W'(op_b);

  // accel = floor(steps*ratio), halved split when cruise would go negative
  assign acc_raw   = prod[MUL_W-1:RATIO_W];
  assign split_big = {acc_raw, 1'b0} > {1'b0, op_a};
  assign acc_n     = split_big ? (op_a >> 1) : acc_raw;
  assign dec_n     = split_big ? (op_a - (op_a >> 1)) : acc_raw;

  // speed from the ramp quotient; decel side floored at start speed
  assign sp_dec  = (dv_quo < NUM_W'(lat_max)) ? lat_max - dv_quo[SPD_W-1:0] : '0;
  assign sp_calc = in_decel ? ((sp_dec < lat_start) ? lat_start : sp_dec)
                            : lat_start + dv_quo[SPD_W-1:0];

  // period split into two halves, each clamped
  assign hi_full    = dv_quo >> 1;
  assign lo_full    = dv_quo - hi_full;
  assign hi_clamp   = (hi_full > NUM_W'(HALF_CLAMP)) ? HALF_CLAMP : hi_full[TIME_W-1:0];
  assign lo_clamp   = (lo_full > NUM_W'(HALF_CLAMP)) ? HALF_CLAMP : lo_full[TIME_W-1:0];
  assign idx_inc    = step_index + 1'b1;
  assign last_pulse = idx_inc >= total_steps;

  // divider launches
  always_comb begin
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    priority if (state == S_IDLE && accept && in_kind == KIND_NEXT && moving &&
                 !in_acc && (in_cru || decel_count == '0)) begin
      // cruise: period straight from max speed
      dv_start = 1'b1;
      dv_num   = NUM_W'(TICK_HZ);
      dv_den   = STEP_W'(lat_max);
    end else if (state == S_MUL && !is_start) begin
      dv_start = 1'b1;
      dv_num   = NUM_W'(mul_out[PROD_W-1:0]);
      dv_den   = den_r;
    end else if (state == S_DIV1 && dv_done) begin
      dv_start = 1'b1;
      dv_num   = NUM_W'(TICK_HZ);
      dv_den   = STEP_W'(sp_calc);
    end else begin
      dv_start = 1'b0;
    end
  end

  stpg_div #(
    .NUM_W (NUM_W),
    .DEN_W (STEP_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // ---------------- sequencer ----------------
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      moving       <= 1'b0;
      step_index   <= '0;
      total_steps  <= '0;
      accel_count  <= '0;
      cruise_count <= '0;
      decel_count  <= '0;
      move_dir     <= 1'b0;
      lat_start    <= '0;
      lat_max      <= '0;
      is_start     <= 1'b0;
      in_decel     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_kind)
              KIND_START: begin
                if (moving) begin
                  state <= S_OUT;
                end else if (bad_start) begin
                  state <= S_OUT;
                end else begin
                  is_start <= 1'b1;
                  state    <= S_MUL;
                end
              end
              KIND_NEXT: begin
                if (!moving) begin
                  state <= S_OUT;
                end else if (in_acc) begin
                  is_start <= 1'b0;
                  in_decel <= 1'b0;
                  state    <= S_MUL;
                end else if (in_cru || decel_count == '0) begin
                  state <= S_DIV2;
                end else begin
                  is_start <= 1'b0;
                  in_decel <= 1'b1;
                  state    <= S_MUL;
                end
              end
              KIND_STOP: begin
                moving <= 1'b0;
                state  <= S_OUT;
              end
              default: ;  // unused kind: no result
            endcase
          end
        end
        S_MUL: begin
          state <= is_start ? S_SPLIT : S_DIV1;
        end
        S_SPLIT: begin
          accel_count  <= acc_n;
          decel_count  <= dec_n;
          cruise_count <= op_a - acc_n - dec_n;
          total_steps  <= op_a;
          step_index   <= '0;
          move_dir     <= res_dir;
          lat_start    <= start_speed_hz;
          lat_max      <= max_speed_hz;
          moving       <= 1'b1;
          state        <= S_OUT;
        end
        S_DIV1: begin
          if (dv_done) begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (dv_done) begin
            step_index <= idx_inc;
            if (last_pulse) begin
              moving <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload side of the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_hi   <= '0;
          res_lo   <= '0;
          res_last <= 1'b0;
          // a good start takes the new direction, everything else keeps the move's
          res_dir  <= (in_kind == KIND_START && !moving && !bad_start) ? in_cw : move_dir;
          unique case (in_kind)
            KIND_START: begin
              op_a <= in_steps;
              op_b <= ramp_ratio_q16;
              if (moving) begin
                res_status <= ST_BUSY;
              end else if (bad_start) begin
                res_status <= ST_BAD;
              end
            end
            KIND_NEXT: begin
              res_status <= moving ? ST_PULSE : ST_IDLE;
              op_b       <= RATIO_W'(diff);
              if (in_acc) begin
                op_a  <= step_index;
                den_r <= accel_count;
              end else begin
                op_a  <= dec_idx;
                den_r <= decel_count;
              end
            end
            KIND_STOP: res_status <= moving ? ST_STOPPED : ST_IDLE;
            default: ;
          endcase
        end
      end
      S_MUL:   prod <= mul_out;
      S_SPLIT: res_status <= ST_STARTED;
      S_DIV2: begin
        if (dv_done) begin
          res_hi   <= hi_clamp;
          res_lo   <= lo_clamp;
          res_last <= last_pulse;
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_status <= res_status;
      out_hi     <= res_hi;
      out_lo     <= res_lo;
      out_dir    <= res_dir;
      out_last   <= res_last;
    end
  end

  assign m_axis_tdata = {M_DATA_W'(0)} |
                        M_DATA_W'({out_dir, out_lo, out_hi, out_status});
  assign m_axis_tlast = out_last;

endmodule

/* rtl/stpg_checker.sv */
module stpg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [stpg_pkg::KIND_W-1:0]   s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [stpg_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import stpg_pkg::*;

  // output register empties on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // only a pulse result can carry last_step
  a_last_pulse: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[STAT_W-1:0] == ST_PULSE)
    else $error("last_step on a non-pulse result");

  // non-pulse results carry no timing
  a_zero_times: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[STAT_W-1:0] != ST_PULSE
      |-> m_axis_tdata[2*TIME_W+STAT_W-1:STAT_W] == '0)
    else $error("timing on a non-pulse result");

  // one item at a time: an item that yields a result closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == KIND_START || s_axis_tuser == KIND_NEXT ||
       s_axis_tuser == KIND_STOP) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind stepper_trapezoid_pulse_gen stpg_checker u_stpg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import stpg_pkg::*;

  // longest quiet stretch (no handshake of any kind) before the run is declared hung
  localparam int QUIET_LIMIT  = 3000;
  // a ramp pulse is the longest item; let the sequencer settle well past it
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEMS_TARGET = 900;

  typedef struct {
    status_t            status;
    logic [TIME_W-1:0]  high_us;
    logic [TIME_W-1:0]  low_us;
    logic               dir;
    logic               last;
  } pulse_res_t;

  logic clk;
  logic rst = 1'b1;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;  // [16:0] step_count, [17] turn_cw
  logic [KIND_W-1:0]   s_axis_tuser  = '0;  // [1:0] kind

  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;        // [2:0] status, [17:3] high, [32:18] low, [33] dir
  logic                m_axis_tlast;        // last_step

  stepper_trapezoid_pulse_gen dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the register file and of the move state
  // ---------------------------------------------------------------------------
  logic [SPD_W-1:0]   cfg_start = START_SPEED_RST;
  logic [SPD_W-1:0]   cfg_max   = MAX_SPEED_RST;
  logic [RATIO_W-1:0] cfg_ratio = RATIO_RST;

  // move state; speeds are latched when a move starts
  bit                 mv_active = 1'b0;
  logic [STEP_W-1:0]  mv_idx    = '0;
  logic [STEP_W-1:0]  mv_total  = '0;
  logic [STEP_W-1:0]  mv_accel  = '0;
  logic [STEP_W-1:0]  mv_cruise = '0;
  logic [STEP_W-1:0]  mv_decel  = '0;
  logic               mv_dir    = 1'b0;
  logic [SPD_W-1:0]   mv_start  = '0;
  logic [SPD_W-1:0]   mv_max    = '0;

  pulse_res_t answers_due[$];
  int         items_sent  = 0;
  int         err_count   = 0;
  bit         src_idle_en = 1'b1;
  bit         snk_idle_en = 1'b1;

  // Works out the answer to one item and advances the move state.
  // Returns 0 for an unused kind, which the block drops without an answer.
  function automatic bit trapezoid_answer(input logic [KIND_W-1:0] kind,
                                          input logic [STEP_W-1:0] steps,
                                          input logic cw,
                                          output pulse_res_t res);
    longint unsigned n, acc, dec, diff, idx, sp, drop, period, hi, lo;
    res.status  = ST_IDLE;
    res.high_us = '0;
    res.low_us  = '0;
    res.dir     = mv_dir;
    res.last    = 1'b0;
    n    = 64'(steps);
    idx  = 64'(mv_idx);
    diff = (mv_max > mv_start) ? 64'(mv_max - mv_start) : 64'd0;
    case (kind)
      KIND_START: begin
        // check order: busy, step count, max speed, start speed, ratio
        if (mv_active) begin
          res.status = ST_BUSY;
        end else if (n == 0 || n > STEP_COUNT_MAX_DEF ||
                     cfg_max < SPEED_LO || cfg_max > SPEED_HI ||
                     cfg_start < SPEED_LO || cfg_start >= cfg_max ||
                     cfg_ratio > RATIO_MAX) begin
          res.status = ST_BAD;
        end else begin
          acc = (n * cfg_ratio) >> 16;
          dec = acc;
          if (2 * acc > n) begin
            acc = n / 2;
            dec = n - acc;
          end
          mv_accel   = STEP_W'(acc);
          mv_decel   = STEP_W'(dec);
          mv_cruise  = STEP_W'(n - acc - dec);
          mv_total   = STEP_W'(n);
          mv_idx     = '0;
          mv_dir     = cw;
          mv_start   = cfg_start;
          mv_max     = cfg_max;
          mv_active  = 1'b1;
          res.status = ST_STARTED;
          res.dir    = cw;
        end
      end
      KIND_NEXT: begin
        if (mv_active) begin
          if (idx < mv_accel) begin
            sp = mv_start + diff * idx / mv_accel;
          end else if (idx < longint'(mv_accel) + mv_cruise) begin
            sp = 64'(mv_max);
          end else begin
            drop = (mv_decel != 0) ?
                   diff * (idx - mv_accel - mv_cruise) / mv_decel : 0;
            sp = (drop < mv_max) ? mv_max - drop : 0;
            // falling ramp never goes under the start speed
            if (sp < mv_start) sp = 64'(mv_start);
          end
          if (sp < 1) sp = 1;
          period = TICK_HZ_DEF / sp;
          hi     = period / 2;
          lo     = period - hi;
          if (hi > HALF_CLAMP) hi = 64'(HALF_CLAMP);
          if (lo > HALF_CLAMP) lo = 64'(HALF_CLAMP);
          mv_idx      = mv_idx + 1'b1;
          res.last    = (mv_idx >= mv_total);
          if (res.last) mv_active = 1'b0;
          res.status  = ST_PULSE;
          res.high_us = hi[TIME_W-1:0];
          res.low_us  = lo[TIME_W-1:0];
        end
      end
      KIND_STOP: begin
        if (mv_active) begin
          mv_active  = 1'b0;
          res.status = ST_STOPPED;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [31:0] reg_value(input logic [REG_W-1:0] idx);
    case (idx)
      REG_START_SPEED: return 32'(cfg_start);
      REG_MAX_SPEED:   return 32'(cfg_max);
      REG_RAMP_RATIO:  return 32'(cfg_ratio);
      default:         return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one item per call, with an optional idle burst ahead of it.
  // tvalid is left high after acceptance so items can go back to back; whoever
  // does something else next must drop it at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [STEP_W-1:0] steps,
                           input logic cw);
    pulse_res_t res;
    int         gap;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {{(S_DATA_W - STEP_W - 1){1'b0}}, cw, steps};
    do @(posedge clk); while (!s_axis_tready);
    if (trapezoid_answer(kind, steps, cw, res)) answers_due.push_back(res);
    if (kind != 2'd3) items_sent++;
  endtask

  task automatic send_noise();
    send_item(KIND_W'($urandom_range(0, 3)), STEP_W'($urandom), 1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Config port
  // ---------------------------------------------------------------------------
  task automatic apb_access(input bit wr, input logic [REG_W-1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic [REG_W-1:0] idx);
    logic [31:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx)) begin
      $error("prdata[%0d]: expected %0d, actual %0d", idx, reg_value(idx), rd);
      err_count++;
    end
  endtask

  // Writes only once every answer is in and the sequencer had time to settle
  // (an unused kind leaves no answer to wait for). Reads the register back.
  task automatic cfg_write(input logic [REG_W-1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] wdata;
    logic [31:0] junk;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    wdata = value;
    junk  = $urandom;
    // upper bits are don't-care; sometimes fill them with garbage
    if ($urandom_range(0, 3) == 0) begin
      if (idx == REG_RAMP_RATIO) wdata = {junk[31:16], value[15:0]};
      else                       wdata = {junk[31:13], value[12:0]};
    end
    apb_access(1'b1, idx, wdata, rd);
    case (idx)
      REG_START_SPEED: cfg_start = wdata[SPD_W-1:0];
      REG_MAX_SPEED:   cfg_max   = wdata[SPD_W-1:0];
      REG_RAMP_RATIO:  cfg_ratio = wdata[RATIO_W-1:0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  task automatic set_speeds(input int start_hz, input int max_hz, input int ratio);
    cfg_write(REG_START_SPEED, start_hz);
    cfg_write(REG_MAX_SPEED, max_hz);
    cfg_write(REG_RAMP_RATIO, ratio);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, and the answer checker
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pulse_res_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        $error("answer with nothing outstanding: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        err_count++;
      end else begin
        exp_res = answers_due.pop_front();
        if (m_axis_tdata[2:0] !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, m_axis_tdata[2:0]);
          err_count++;
        end
        if (m_axis_tdata[17:3] !== exp_res.high_us) begin
          $error("high_time_us: expected %0d, actual %0d", exp_res.high_us, m_axis_tdata[17:3]);
          err_count++;
        end
        if (m_axis_tdata[32:18] !== exp_res.low_us) begin
          $error("low_time_us: expected %0d, actual %0d", exp_res.low_us, m_axis_tdata[32:18]);
          err_count++;
        end
        if (m_axis_tdata[33] !== exp_res.dir) begin
          $error("dir_level: expected %0d, actual %0d", exp_res.dir, m_axis_tdata[33]);
          err_count++;
        end
        if (m_axis_tlast !== exp_res.last) begin
          $error("last_step: expected %0d, actual %0d", exp_res.last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // watchdog: any handshake on any port counts as progress
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // registers come up at their defaults; next/stop while idle answer idle
  task automatic test_reset_defaults();
    check_reg(REG_START_SPEED);
    check_reg(REG_MAX_SPEED);
    check_reg(REG_RAMP_RATIO);
    send_item(KIND_NEXT, '0, 1'b0);
    send_item(KIND_STOP, '1, 1'b1);
    send_item(2'd3, '1, 1'b1);  // unused kind, dropped
  endtask

  task automatic test_directed_moves();
    // single-step move: no ramp, one cruise pulse that is also the last
    send_item(KIND_START, 17'd1, 1'b1);
    send_item(KIND_NEXT, '0, 1'b0);
    // step count zero and all-ones are rejected
    send_item(KIND_START, 17'd0, 1'b0);
    send_item(KIND_START, '1, 1'b1);
    // start while moving is busy, then stop mid-move and stop again while idle
    send_item(KIND_START, 17'd5, 1'b0);
    send_item(KIND_START, 17'd7, 1'b1);
    send_item(KIND_NEXT, '0, 1'b0);
    send_item(KIND_STOP, '0, 1'b0);
    send_item(KIND_STOP, '0, 1'b0);
    // largest legal move, aborted early; an unused kind in between
    send_item(KIND_START, 17'(STEP_COUNT_MAX_DEF), 1'b1);
    send_item(KIND_NEXT, '1, 1'b1);
    send_item(2'd3, '0, 1'b0);
    send_item(KIND_STOP, '0, 1'b1);
  endtask

  task automatic test_config_extremes();
    // widest speed span with the steepest ramp: no cruise at all
    set_speeds(int'(SPEED_LO), int'(SPEED_HI), int'(RATIO_MAX));
    send_item(KIND_START, 17'd4, 1'b1);
    repeat (4) send_item(KIND_NEXT, '0, 1'b0);
    // flat profile; max speed rewritten mid-move must not affect it
    cfg_write(REG_RAMP_RATIO, 0);
    send_item(KIND_START, 17'd2, 1'b0);
    send_item(KIND_NEXT, '0, 1'b0);
    cfg_write(REG_MAX_SPEED, 300);
    send_item(KIND_NEXT, '0, 1'b0);
    // start speed equal to max is rejected
    cfg_write(REG_START_SPEED, 300);
    send_item(KIND_START, 17'd3, 1'b1);
  endtask

  // Mostly complete moves under random speed settings, with aborts, busy
  // starts and junk items mixed in. Now and then the settings are invalid.
  task automatic test_random_moves();
    int n_moves;
    int steps;
    int stop_at;
    int k;
    int s_hz;
    int r;
    while (items_sent < ITEMS_TARGET) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 6))
          0: set_speeds(200, 99, $urandom_range(0, 32768));
          1: set_speeds(200, 5001, $urandom_range(0, 32768));
          2: set_speeds(99, 5000, $urandom_range(0, 32768));
          3: begin
            s_hz = $urandom_range(100, 5000);
            set_speeds(s_hz, s_hz, $urandom_range(0, 32768));
          end
          4: set_speeds(100, 5000, 32769);
          5: set_speeds(8191, 8191, 65535);
          default: set_speeds($urandom_range(0, 8191), $urandom_range(0, 8191),
                              $urandom_range(0, 65535));
        endcase
      end else if (r == 1) begin
        set_speeds(int'(SPEED_LO), int'(SPEED_HI),
                   ($urandom_range(0, 1) != 0) ? int'(RATIO_MAX) : 0);
      end else begin
        s_hz = $urandom_range(100, 4999);
        set_speeds(s_hz, $urandom_range(s_hz + 1, 5000), $urandom_range(0, 32768));
      end
      n_moves = $urandom_range(2, 5);
      repeat (n_moves) begin
        r = $urandom_range(0, 19);
        if (r == 0)      steps = $urandom_range(0, 131071);
        else if (r == 1) steps = $urandom_range(41, 300);
        else             steps = $urandom_range(1, 40);
        send_item(KIND_START, STEP_W'(steps), 1'($urandom));
        if (mv_active) begin
          // long moves are always cut short; short ones sometimes
          if (mv_total - mv_idx > 300)      stop_at = $urandom_range(0, 30);
          else if ($urandom_range(0, 4) == 0) stop_at = $urandom_range(0, 20);
          else                              stop_at = -1;
          k = 0;
          while (mv_active) begin
            if (k == stop_at)                 send_item(KIND_STOP, STEP_W'($urandom), 1'($urandom));
            else if ($urandom_range(0, 15) == 0) send_noise();
            else                              send_item(KIND_NEXT, STEP_W'($urandom), 1'($urandom));
            k++;
          end
        end else begin
          repeat ($urandom_range(1, 2)) send_noise();
        end
      end
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    int s_hz;
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    s_hz = $urandom_range(100, 2000);
    set_speeds(s_hz, $urandom_range(s_hz + 1, 5000), $urandom_range(0, 32768));
    repeat (3) begin
      send_item(KIND_START, STEP_W'($urandom_range(5, 20)), 1'($urandom));
      while (mv_active) send_item(KIND_NEXT, STEP_W'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed_moves();
    test_config_extremes();
    test_random_moves();
    test_steady_stream();

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
